FILE: design/spr_pkg.sv
package spr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 4;

   localparam logic [BYTE_W-1:0] CMD_WRITE_BIT = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_LEN_MASK  = 8'h07;

   localparam logic [BYTE_W-1:0] DFLT_LOW_LAST = 8'h05;
   localparam logic [BYTE_W-1:0] DFLT_LOW_VAL  = 8'hff;
   localparam logic [BYTE_W-1:0] DFLT_A_ADDR   = 8'h21;
   localparam logic [BYTE_W-1:0] DFLT_A_VAL    = 8'd232;
   localparam logic [BYTE_W-1:0] DFLT_B_ADDR   = 8'h52;
   localparam logic [BYTE_W-1:0] DFLT_B_VAL    = 8'd224;
   localparam logic [BYTE_W-1:0] DFLT_C_ADDR   = 8'h5a;
   localparam logic [BYTE_W-1:0] DFLT_C_VAL    = 8'h06;

   // frame phase, one-hot
   typedef enum logic [4:0] {
      PH_CMD  = 5'b00001,
      PH_ADDR = 5'b00010,
      PH_HIGH = 5'b00100,
      PH_WR   = 5'b01000,
      PH_RD   = 5'b10000
   } spr_phase_type;

   // register file write request
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } spr_wr_type;

   // value a register holds after reset
   function automatic logic [BYTE_W-1:0] reg_default(input logic [BYTE_W-1:0] a);
      logic [BYTE_W-1:0] v;
      v = '0;
      if (a <= DFLT_LOW_LAST)    v = DFLT_LOW_VAL;
      else if (a == DFLT_A_ADDR) v = DFLT_A_VAL;
      else if (a == DFLT_B_ADDR) v = DFLT_B_VAL;
      else if (a == DFLT_C_ADDR) v = DFLT_C_VAL;
      return v;
   endfunction

endpackage

FILE: design/spi_pmic_register_frame.sv
// SPI register frame engine: one request (a byte from the host) in, one
// response byte out, at one request per cycle while req_stall is low; the
// reply is registered. A frame is a command byte (bit 7 write, bits 2:0
// length minus one), an address byte and an ignored high-address byte,
// followed by length data bytes all aimed at the same register. Header
// and write-data bytes answer zero; read-data bytes answer the register.
// The register file is a synchronous memory read continuously at the
// frame address; the address is known two requests before the first data
// byte, so the registered memory read never stalls the stream. Per-entry
// valid bits make unwritten registers read their reset defaults without a
// clearing pass. A response register parts the two sides; req_stall rises
// only while a response waits under rsp_stall.
module spi_pmic_register_frame #(
   parameter int unsigned REG_COUNT = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [spr_pkg::BYTE_W-1:0] req_tx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [spr_pkg::BYTE_W-1:0] rsp_rx_byte
);
   import spr_pkg::*;

   logic              accept;
   spr_wr_type        wr;
   logic [BYTE_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_byte;
   logic              rd_sel;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   spr_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .tx_byte (req_tx_byte),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_sel  (rd_sel)
   );

   spr_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_byte (rd_byte)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = rd_sel ? rd_byte : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rx_byte = rsp_byte_ff;

endmodule

FILE: design/spr_regfile.sv
module spr_regfile #(
   parameter int unsigned REG_COUNT = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spr_pkg::spr_wr_type       wr,
   input  logic [spr_pkg::BYTE_W-1:0] rd_addr,
   output logic [spr_pkg::BYTE_W-1:0] rd_byte
);
   import spr_pkg::*;

   localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   logic [BYTE_W-1:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;

   logic              wr_ok;
   logic              rd_ok;
   logic [AW-1:0]     wr_idx;
   logic [AW-1:0]     rd_idx;

   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] rd_dflt_ff;
   logic              rd_valid_ff;
   logic              rd_ok_ff;

   assign wr_ok  = {1'b0, wr.addr} < (BYTE_W+1)'(REG_COUNT);
   assign rd_ok  = {1'b0, rd_addr} < (BYTE_W+1)'(REG_COUNT);
   assign wr_idx = wr.addr[AW-1:0];
   assign rd_idx = rd_addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en && wr_ok) begin
         mem[wr_idx] <= wr.data;
      end
   end

   // entry not yet written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr_ok) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_ok) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
      rd_dflt_ff <= reg_default(rd_addr);
      rd_ok_ff   <= rd_ok;
   end

   assign rd_byte = !rd_ok_ff   ? '0 :
                    rd_valid_ff ? rd_data_ff : rd_dflt_ff;

endmodule

FILE: design/spr_frame.sv
module spr_frame (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [spr_pkg::BYTE_W-1:0] tx_byte,
   output spr_pkg::spr_wr_type        wr,
   output logic [spr_pkg::BYTE_W-1:0] rd_addr,
   output logic                       rd_sel
);
   import spr_pkg::*;

   spr_phase_type     phase_ff, phase_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  left_ff, left_in;

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      wr.en    = 1'b0;
      wr.addr  = addr_ff;
      wr.data  = tx_byte;
      rd_sel   = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_CMD: begin
               cmd_in   = tx_byte;
               phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               addr_in  = tx_byte;
               phase_in = PH_HIGH;
            end
            PH_HIGH: begin
               left_in  = LEN_W'(cmd_ff & CMD_LEN_MASK) + LEN_W'(1);
               phase_in = ((cmd_ff & CMD_WRITE_BIT) != '0) ? PH_WR : PH_RD;
            end
            PH_WR, PH_RD: begin
               if (left_ff != '0) begin
                  wr.en   = (phase_ff == PH_WR);
                  rd_sel  = (phase_ff == PH_RD);
                  left_in = left_ff - LEN_W'(1);
                  if (left_ff == LEN_W'(1)) phase_in = PH_CMD;
               end
            end
            default: phase_in = PH_CMD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD;
         cmd_ff   <= '0;
         addr_ff  <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
      end
   end

   // address is settled two requests before any data byte
   assign rd_addr = addr_ff;

endmodule

FILE: design/spr_checker.sv
module spr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_rx_byte
);

   // every accepted request yields a response on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // no response appears without a request accepted just before
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response without request");

   // back-pressure only while a response is held
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with response side free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rx_byte))
      else $error("stalled response changed");

endmodule

bind spi_pmic_register_frame spr_checker u_spr_checker (.*);
